FILE: src/rffa_pkg.sv
package rffa_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic signed [31:0] particle_x;
      logic signed [31:0] particle_y;
      logic signed [31:0] particle_z;
      logic signed [31:0] base_force_x;
      logic signed [31:0] base_force_y;
      logic signed [31:0] base_force_z;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic        [30:0] radius;
      logic signed [31:0] strength;
      logic               last_field;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
   } rsp_type;

   // One classified field item as handed from the front to the back.
   typedef struct packed {
      logic                     first;
      logic                     last;
      logic                     apply;
      logic [2:0]               dneg;
      logic [2:0][30:0]         dabs;
      logic [30:0]              radius;
      logic signed [31:0]       strength;
      logic [2:0][31:0]         base;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic busy;
      logic finishing;
   } back_status_type;

endpackage

FILE: src/rffa_front.sv
module rffa_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rffa_pkg::req_type req_data,
   input  rffa_pkg::queue_status_type q_status,
   output logic              push,
   output rffa_pkg::entry_type push_entry
);
   import rffa_pkg::*;

   logic               run_open_ff;
   logic signed [32:0] dx, dy, dz;
   logic        [32:0] ax, ay, az;
   logic        [32:0] r_ext;

   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall;

   always_comb begin
      dx    = 33'(req_data.center_x) - 33'(req_data.particle_x);
      dy    = 33'(req_data.center_y) - 33'(req_data.particle_y);
      dz    = 33'(req_data.center_z) - 33'(req_data.particle_z);
      ax    = dx[32] ? 33'(-dx) : 33'(dx);
      ay    = dy[32] ? 33'(-dy) : 33'(dy);
      az    = dz[32] ? 33'(-dz) : 33'(dz);
      r_ext = {2'b00, req_data.radius};

      push_entry.first   = !run_open_ff;
      push_entry.last    = req_data.last_field;
      // A field can only reach the particle if every axis offset is inside the radius.
      push_entry.apply   = (req_data.radius != 31'd0) && (ax < r_ext) && (ay < r_ext)
                           && (az < r_ext);
      push_entry.dneg    = {dz[32], dy[32], dx[32]};
      push_entry.dabs[0] = ax[30:0];
      push_entry.dabs[1] = ay[30:0];
      push_entry.dabs[2] = az[30:0];
      push_entry.radius  = req_data.radius;
      push_entry.strength = req_data.strength;
      push_entry.base[0] = req_data.base_force_x;
      push_entry.base[1] = req_data.base_force_y;
      push_entry.base[2] = req_data.base_force_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
      end else if (push) begin
         run_open_ff <= !req_data.last_field;
      end
   end

endmodule

FILE: src/rffa_queue.sv
module rffa_queue #(
   parameter int DEPTH = rffa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rffa_pkg::entry_type        push_entry,
   input  logic                       pop,
   output rffa_pkg::entry_type        head,
   output rffa_pkg::queue_status_type status
);
   import rffa_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: src/rffa_back.sv
module rffa_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rffa_pkg::queue_status_type q_status,
   input  rffa_pkg::entry_type        head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rffa_pkg::rsp_type          rsp_data,
   output rffa_pkg::back_status_type  status
);
   import rffa_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_ADD  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0]         state_ff;
   logic [4:0]         cnt_ff;
   logic [1:0]         phase_ff;
   entry_type          ent_ff;
   logic signed [31:0] acc_ff [3];
   logic [61:0]        p_ff;
   logic [63:0]        sum_ff;
   logic [63:0]        rem_ff, root_ff, bit_ff;
   logic [30:0]        d_ff;
   logic [31:0]        mag_ff;
   logic [30:0]        dvr_ff, drem_ff;
   logic [31:0]        dq_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [31:0]        mul_a, mul_b, sabs;
   logic [63:0]        prod;
   logic [63:0]        root_try, rem_in, root_in;
   logic [31:0]        div_sh, div_diff;
   logic               div_ge;
   logic [1:0]         axis;
   logic signed [33:0] q_signed, acc_sum;
   logic signed [31:0] acc_sat;
   logic               rsp_load;

   assign pop              = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.busy      = (state_ff != ST_IDLE);
   assign status.finishing = (state_ff == ST_FIN);
   assign rsp_load         = (state_ff == ST_FIN) && ent_ff.last
                             && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      sabs = ent_ff.strength[31] ? 32'(-ent_ff.strength) : 32'(ent_ff.strength);
      axis = phase_ff - 2'd1;
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_SQ) begin
         case (cnt_ff[1:0])
            2'd0:    begin mul_a = {1'b0, ent_ff.dabs[0]}; mul_b = {1'b0, ent_ff.dabs[0]}; end
            2'd1:    begin mul_a = {1'b0, ent_ff.dabs[1]}; mul_b = {1'b0, ent_ff.dabs[1]}; end
            2'd2:    begin mul_a = {1'b0, ent_ff.dabs[2]}; mul_b = {1'b0, ent_ff.dabs[2]}; end
            default: begin mul_a = {1'b0, ent_ff.radius};  mul_b = {1'b0, ent_ff.radius};  end
         endcase
      end else if (phase_ff == 2'd0) begin
         mul_a = sabs;
         mul_b = {1'b0, ent_ff.radius - d_ff};
      end else begin
         mul_a = mag_ff;
         mul_b = {1'b0, ent_ff.dabs[axis]};
      end
      prod = 64'(mul_a) * 64'(mul_b);

      // One step of the bit-pair square root.
      root_try = root_ff + bit_ff;
      if (rem_ff >= root_try) begin
         rem_in  = rem_ff - root_try;
         root_in = (root_ff >> 1) + bit_ff;
      end else begin
         rem_in  = rem_ff;
         root_in = root_ff >> 1;
      end

      // One step of the restoring divide; the partial remainder stays below the divisor.
      div_sh   = {drem_ff, dq_ff[31]};
      div_ge   = div_sh >= {1'b0, dvr_ff};
      div_diff = div_sh - {1'b0, dvr_ff};

      q_signed = (ent_ff.strength[31] ^ ent_ff.dneg[axis]) ? -{2'b00, dq_ff}
                                                           :  {2'b00, dq_ff};
      acc_sum  = 34'(acc_ff[axis]) + q_signed;
      if (acc_sum > 34'sd2147483647) begin
         acc_sat = 32'sh7FFFFFFF;
      end else if (acc_sum < -34'sd2147483648) begin
         acc_sat = 32'sh80000000;
      end else begin
         acc_sat = acc_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         phase_ff     <= '0;
         acc_ff[0]    <= '0;
         acc_ff[1]    <= '0;
         acc_ff[2]    <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  ent_ff <= head;
                  if (head.first) begin
                     acc_ff[0] <= head.base[0];
                     acc_ff[1] <= head.base[1];
                     acc_ff[2] <= head.base[2];
                  end
                  cnt_ff   <= '0;
                  state_ff <= head.apply ? ST_SQ : ST_FIN;
               end
            end
            ST_SQ: begin
               p_ff <= prod[61:0];
               case (cnt_ff[2:0])
                  3'd0:    sum_ff <= '0;
                  3'd1:    sum_ff <= {2'b00, p_ff};
                  default: sum_ff <= sum_ff + {2'b00, p_ff};
               endcase
               cnt_ff <= (cnt_ff == 5'd4) ? '0 : cnt_ff + 1'b1;
               // When cnt_ff reaches 4, p_ff holds the squared radius.
               if (cnt_ff == 5'd4) begin
                  if ((sum_ff < {2'b00, p_ff}) && (sum_ff != '0)) begin
                     rem_ff   <= sum_ff;
                     root_ff  <= '0;
                     bit_ff   <= 64'd1 << 62;
                     state_ff <= ST_SQRT;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_SQRT: begin
               rem_ff  <= rem_in;
               root_ff <= root_in;
               bit_ff  <= bit_ff >> 2;
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd31) begin
                  d_ff     <= root_in[30:0];
                  phase_ff <= 2'd0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               drem_ff  <= prod[62:32];
               dq_ff    <= prod[31:0];
               dvr_ff   <= (phase_ff == 2'd0) ? ent_ff.radius : d_ff;
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               drem_ff <= div_ge ? div_diff[30:0] : div_sh[30:0];
               dq_ff   <= {dq_ff[30:0], div_ge};
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd31) begin
                  if (phase_ff == 2'd0) begin
                     mag_ff   <= {dq_ff[30:0], div_ge};
                     phase_ff <= 2'd1;
                     state_ff <= ST_MUL;
                  end else begin
                     state_ff <= ST_ADD;
                  end
               end
            end
            ST_ADD: begin
               acc_ff[axis] <= acc_sat;
               if (phase_ff == 2'd3) begin
                  state_ff <= ST_FIN;
               end else begin
                  phase_ff <= phase_ff + 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_FIN: begin
               if (!ent_ff.last) begin
                  state_ff <= ST_IDLE;
               end else if (rsp_load) begin
                  rsp_data_ff.force_x <= acc_ff[0];
                  rsp_data_ff.force_y <= acc_ff[1];
                  rsp_data_ff.force_z <= acc_ff[2];
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: src/radial_force_field_accumulate.sv
// Radial force field accumulator with linear falloff.
// The req_ channel takes one beat per force field; a run of beats belongs to one
// particle and ends with the beat whose last_field is set. The first beat of a run
// also loads the particle's existing force. The rsp_ channel delivers one beat per
// run with the saturated sum of all field pushes.
// The front classifies each beat in the cycle it is accepted and writes it to a short
// queue, so req_ beats are taken while the back is busy until the queue fills.
// The back works one field at a time on a shared multiplier and a one-bit-per-cycle
// square root and divider: a field with an axis offset at or beyond the radius only
// takes the beat and the finish step; one that passes that test but lies at or beyond
// the radius or at zero distance also forms the squares; and a field that applies
// takes the beat, forms the squares, takes the root, and runs four multiply and divide
// passes, three adds and the finish step. The response appears in the cycle after the
// last field of a run is finished.
// A result waits in the output register while rsp_stall is high; the back then holds
// at the end of its next run, and the queue keeps filling until it is full.
// Reset clears the queue, the output valid, the accumulator and the run state, so the
// next beat starts a new run.
module radial_force_field_accumulate #(
   parameter int QUEUE_DEPTH = rffa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rffa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rffa_pkg::rsp_type rsp_data
);
   import rffa_pkg::*;

   logic             push, pop;
   entry_type        push_entry, head;
   queue_status_type q_status;
   back_status_type  b_status;

   rffa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   rffa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   rffa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (b_status)
   );

   a_queue_state : assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   a_push_visible : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !q_status.empty)
      else $error("accepted beat did not reach the queue");

   a_rsp_from_fin : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(b_status.finishing))
      else $error("response raised outside the finish step");

   a_pop_idle : assert property (@(posedge clock) disable iff (reset)
      pop |-> !b_status.busy && !q_status.empty)
      else $error("queue popped while back is busy or queue is empty");

endmodule
